// ===== hdl/pdmcic_pkg.sv =====
// Shared constants and types for the PDM CIC5 decimate-by-16 core.
package pdmcic_pkg;

  // Filter structure
  localparam int STAGES        = 5;
  localparam int WORD_BITS     = 16;
  localparam int SAMPLE_W      = 16;
  localparam int SHIFT_W       = 4;
  localparam int ACC_WIDTH_DEF = 22;

  // Reset value of the output shift register
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;

  // Queue depths (powers of two)
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;

  // One result item
  typedef struct packed {
    logic                       overflow;
    logic signed [SAMPLE_W-1:0] sample;
  } out_item_t;

endpackage

// ===== hdl/pdmcic_fifo.sv =====
// Small register-based FIFO with valid/ready style status.
module pdmcic_fifo
  import pdmcic_pkg::*;
#(
  parameter int W     = 16,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [AW:0]  wr_ptr;
  logic [AW:0]  rd_ptr;

  assign nonempty = (wr_ptr != rd_ptr);
  assign full     = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign dout     = mem[rd_ptr[AW-1:0]];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[AW-1:0]] <= din;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && nonempty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pdmcic_integ.sv =====
// Bit-serial front of the filter: word unpacking and skewed integrator cascade.
module pdmcic_integ
  import pdmcic_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 word_valid,
  input  logic [WORD_BITS-1:0] word,
  input  logic                 credit_ok,
  output logic                 word_pop,
  output logic                 res_valid,
  output logic [ACC_WIDTH-1:0] res_value
);

  localparam int CNT_W = $clog2(WORD_BITS);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS-1:0] shreg;
  logic                 last_bit;
  logic                 load;

  // Per-stage accumulators and tags: stage k holds its value for bit (t - k)
  logic [ACC_WIDTH-1:0] acc [STAGES];
  logic [STAGES-1:0]    vld;
  logic [STAGES-1:0]    lst;

  assign last_bit = busy && (cnt == CNT_W'(WORD_BITS - 1));
  assign load     = word_valid && credit_ok && (!busy || last_bit);
  assign word_pop = load;

  // Bit sequencer: one PDM bit per cycle, MSB first, next word back to back when one is queued and credit allows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !last_bit;
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= word;
    end else if (busy) begin
      shreg <= {shreg[WORD_BITS-2:0], 1'b0};
    end
  end

  // First integrator: +1 for a one, -1 for a zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc[0] <= '0;
      vld[0] <= 1'b0;
      lst[0] <= 1'b0;
    end else begin
      vld[0] <= busy;
      lst[0] <= last_bit;
      if (busy) begin
        acc[0] <= acc[0] + (shreg[WORD_BITS-1] ? ACC_WIDTH'(1) : {ACC_WIDTH{1'b1}});
      end
    end
  end

  // Later integrators add the previous stage's value in the cycle after that stage updates it
  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        acc[k] <= '0;
        vld[k] <= 1'b0;
        lst[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
        lst[k] <= vld[k-1] && lst[k-1];
        if (vld[k-1]) begin
          acc[k] <= acc[k] + acc[k-1];
        end
      end
    end
  end

  // Last integrator after the word's final bit
  assign res_valid = vld[STAGES-1] && lst[STAGES-1];
  assign res_value = acc[STAGES-1];

endmodule

// ===== hdl/pdmcic_comb.sv =====
// Back of the filter: sequential comb section, output shift and range check.
module pdmcic_comb
  import pdmcic_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [SHIFT_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  input  logic [ACC_WIDTH-1:0] in_value,
  output logic                 item_valid,
  output out_item_t            item
);

  localparam int IDX_W = $clog2(STAGES);

  logic [SHIFT_W-1:0]   output_shift;
  logic [ACC_WIDTH-1:0] dly [STAGES];
  logic [ACC_WIDTH-1:0] v;
  logic [IDX_W-1:0]     idx;
  logic                 busy;
  logic                 fin;
  logic [ACC_WIDTH-1:0] diff;
  logic signed [ACC_WIDTH-1:0] sh;
  logic [ACC_WIDTH-SAMPLE_W:0] hi;

  // Shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_shift <= SHIFT_RESET;
    end else if (cfg_wr_en) begin
      output_shift <= cfg_wr_data;
    end
  end

  assign diff = v - dly[idx];

  // Comb sequencer: one differencer per cycle; the output shift acts combinationally on the final difference
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      idx  <= '0;
      for (int i = 0; i < STAGES; i++) begin
        dly[i] <= '0;
      end
    end else begin
      fin <= 1'b0;
      if (in_valid) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        dly[idx] <= v;
        if (idx == IDX_W'(STAGES - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      v <= in_value;
    end else if (busy) begin
      v <= diff;
    end
  end

  // Arithmetic shift, keep low bits, flag values outside 16-bit range
  assign sh = $signed(v) >>> output_shift;
  assign hi = sh[ACC_WIDTH-1:SAMPLE_W-1];

  assign item_valid    = fin;
  assign item.sample   = sh[SAMPLE_W-1:0];
  assign item.overflow = !((hi == '0) || (hi == '1));

endmodule

// ===== hdl/pdm_cic5_decimator_by16_core.sv =====
// Top level of the fifth-order CIC PDM decimator (decimate by 16).
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------
//  input    | in_valid / in_ready  | pdm_word[15:0]
//  output   | out_valid/ out_ready | sample[15:0] (signed), overflow
//  config   | cfg_wr_en            | cfg_wr_data[3:0] (output shift)
//
// The integrator cascade takes one PDM bit per cycle; the next queued word starts
// on the last bit of the one before when the output credit allows.
// Synchronous reset clears all integrators, comb delays and queues and sets
// the output shift to 3. Input items queue two deep; up to four results wait
// at the output while the downstream stalls before the input side holds off.
module pdm_cic5_decimator_by16_core
  import pdmcic_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [WORD_BITS-1:0]       pdm_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       overflow,
  input  logic                       cfg_wr_en,
  input  logic [SHIFT_W-1:0]         cfg_wr_data
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic                 in_full;
  logic                 word_valid;
  logic [WORD_BITS-1:0] word;
  logic                 word_pop;
  logic                 credit_ok;
  logic                 int_valid;
  logic [ACC_WIDTH-1:0] int_value;
  logic                 item_valid;
  out_item_t            item;
  out_item_t            out_item;
  logic                 out_full;
  logic [CW-1:0]        in_flight;
  logic                 out_take;

  // Input queue
  assign in_ready = !in_full;

  pdmcic_fifo #(
    .W     (WORD_BITS),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid),
    .din      (pdm_word),
    .full     (in_full),
    .pop      (word_pop),
    .dout     (word),
    .nonempty (word_valid)
  );

  // Words started but not yet delivered; bounds the output queue
  assign out_take  = out_valid && out_ready;
  assign credit_ok = (in_flight < CW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      case ({word_pop, out_take})
        2'b10:   in_flight <= in_flight + 1'b1;
        2'b01:   in_flight <= in_flight - 1'b1;
        default: in_flight <= in_flight;
      endcase
    end
  end

  // Integrators
  pdmcic_integ #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_integ (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .credit_ok  (credit_ok),
    .word_pop   (word_pop),
    .res_valid  (int_valid),
    .res_value  (int_value)
  );

  // Combs and output scaling
  pdmcic_comb #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_comb (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (int_valid),
    .in_value    (int_value),
    .item_valid  (item_valid),
    .item        (item)
  );

  // Output queue; never full on push thanks to the credit count
  pdmcic_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (item_valid),
    .din      (item),
    .full     (out_full),
    .pop      (out_ready),
    .dout     (out_item),
    .nonempty (out_valid)
  );

  assign sample   = out_item.sample;
  assign overflow = out_item.overflow && !out_full | out_item.overflow;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the PDM CIC5 decimate-by-16 core.
module testbench
  import pdmcic_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACC_W       = ACC_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYC  = 40;
  localparam int DIR_ROWS    = 27;
  localparam int PHASE_BLKS  = 4;
  localparam int BLK_ITEMS   = 46;

  // Directed table: an item to send or a shift value to program
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [WORD_BITS-1:0]   value;
    logic                   has_exp;
    logic                   exp_ovf;
    logic [SAMPLE_W-1:0]    exp_sample;
  } dir_row_t;

  // DUT signals; the driven inputs are known from time zero
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [WORD_BITS-1:0]       pdm_word = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       overflow;
  logic                       cfg_wr_en = 1'b0;
  logic [SHIFT_W-1:0]         cfg_wr_data = '0;

  // Predictor state
  logic [ACC_W-1:0]   integ    [STAGES] = '{default: '0};
  logic [ACC_W-1:0]   comb_dly [STAGES] = '{default: '0};
  logic [SHIFT_W-1:0] shift_cfg = SHIFT_RESET;

  out_item_t pending_results[$];
  out_item_t want;
  int        errors = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // After reset a full-scale word gives the fifth-order ramp C(20,5) = 15504, >>> 3
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, 16'hFFFF, 1'b1, 1'b0, 16'd1938},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hAAAA, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h5555, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h8000, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0001, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFF00, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h00FF, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  16'd0,    1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  16'd15,   1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  16'd3,    1'b0, 1'b0, 16'd0}
  };

  pdm_cic5_decimator_by16_core #(
    .ACC_WIDTH (ACC_W)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pdm_word    (pdm_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample      (sample),
    .overflow    (overflow),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Run the sixteen bits through the integrators, then one comb pass
  function automatic out_item_t cic_predict(input logic [WORD_BITS-1:0] w);
    logic [ACC_W-1:0]   v;
    logic [ACC_W-1:0]   d;
    logic signed [63:0] wide;
    logic signed [63:0] shifted;
    out_item_t          r;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      integ[0] = integ[0] + (w[k] ? ACC_W'(1) : {ACC_W{1'b1}});
      for (int i = 1; i < STAGES; i++)
        integ[i] = integ[i] + integ[i-1];
    end
    v = integ[STAGES-1];
    for (int i = 0; i < STAGES; i++) begin
      d           = v - comb_dly[i];
      comb_dly[i] = v;
      v           = d;
    end
    wide       = {{(64-ACC_W){v[ACC_W-1]}}, v};
    shifted    = wide >>> shift_cfg;
    r.sample   = shifted[SAMPLE_W-1:0];
    r.overflow = (shifted > 64'sd32767) || (shifted < -64'sd32768);
    return r;
  endfunction

  // Random word: constant extremes, uniform bits, or bits at a set density
  function automatic logic [WORD_BITS-1:0] rand_word(input int density);
    logic [WORD_BITS-1:0] w;
    int                   pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      w = '0;
    end else if (pick < 4) begin
      w = '1;
    end else if (pick < 11) begin
      w = WORD_BITS'($urandom);
    end else begin
      for (int k = 0; k < WORD_BITS; k++)
        w[k] = ($urandom_range(0, 99) < density);
    end
    return w;
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return SHIFT_W'($urandom_range(0, 3));
      default: return SHIFT_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Send one item; called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [WORD_BITS-1:0] w, input logic use_typed,
                           input out_item_t typed);
    out_item_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pdm_word <= w;
    do @(posedge clk); while (!in_ready);
    predicted = cic_predict(w);
    pending_results.push_back(use_typed ? typed : predicted);
    @(negedge clk);
  endtask

  // Program the shift once every pending result has drained
  task automatic write_shift(input logic [SHIFT_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shift_cfg = val;
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result sample %0d overflow %0b", $time, sample, overflow);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (sample !== want.sample) begin
          $display("%0t: sample expected %0d got %0d", $time, want.sample, sample);
          errors++;
        end
        if (overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b got %0b", $time, want.overflow, overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int density;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG)
        write_shift(dir_tab[r].value[SHIFT_W-1:0]);
      else
        send_word(dir_tab[r].value, dir_tab[r].has_exp,
                  {dir_tab[r].exp_ovf, dir_tab[r].exp_sample});
    end

    // Random part: two idling phases and one without idling, new shift every block
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 22; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int b = 0; b < PHASE_BLKS; b++) begin
        write_shift(pick_shift());
        density = $urandom_range(0, 100);
        for (int n = 0; n < BLK_ITEMS; n++)
          send_word(rand_word(density), 1'b0, '0);
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pdmcic_pkg.sv
hdl/pdmcic_fifo.sv
hdl/pdmcic_integ.sv
hdl/pdmcic_comb.sv
hdl/pdm_cic5_decimator_by16_core.sv
tb/testbench.sv
